// ===== hw/rtl/fpba_pkg.sv =====
// Shared types and constants of the fit-policy block allocator.
`timescale 1ns / 1ps

package fpba_pkg;

	localparam int MAX_BLOCKS = 32;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 6;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_FIT_MODE   = 2'd0,
		CFG_NUM_BLOCKS = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_mode_t;

	typedef enum logic {
		REQ_LOAD     = 1'b0,
		REQ_ALLOCATE = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [4:0]  block_index;
		logic [15:0] amount;
	} req_t;

	typedef struct packed {
		logic        granted;
		logic [4:0]  block_number;
		logic [15:0] remaining;
	} rsp_t;

endpackage

// ===== hw/rtl/fit_policy_block_allocator.sv =====
// Top level of the fit-policy block allocator: free-size table and search sequencer.
`timescale 1ns / 1ps

// The block keeps a free size for each of MAX_BLOCKS blocks in a one-port-read,
// one-port-write RAM and searches it one entry per cycle. A load word writes its
// entry directly. An allocate word scans blocks 0 to num_blocks-1 (saturated to
// MAX_BLOCKS) through the RAM read port, then writes the charged entry back when
// one fits and posts the result; the block takes no new word until the result is
// posted. A finished result waits in the output register while the next word is
// accepted. After reset every entry reads as zero through per-entry valid flags,
// so no clearing pass is needed. Configuration writes are always ready.
module fit_policy_block_allocator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  fpba_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output fpba_pkg::rsp_t                       rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fpba_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	import fpba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	state_t              state_q;
	fit_mode_t           fit_mode_q;
	logic [5:0]          num_blocks_q;
	logic [MAX_BLOCKS-1:0] filled_q;

	fit_mode_t           mode_q;
	logic [CNT_BITS-1:0] active_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [SIZE_BITS-1:0] amt_q;
	logic                found_q;
	logic [IDX_BITS-1:0] pick_q;
	logic [SIZE_BITS-1:0] best_q;

	logic                rd_vld_s1;
	logic [IDX_BITS-1:0] rd_idx_s1;

	logic                accept;
	logic                finish;
	logic                ram_we;
	logic [IDX_BITS-1:0] ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;
	logic                ram_re;
	logic [SIZE_BITS-1:0] ram_rdata;
	logic [SIZE_BITS-1:0] entry_size;
	logic                take;
	logic [CNT_BITS-1:0] active_sat;
	logic [SIZE_BITS-1:0] left_size;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign finish    = (state_q == ST_DONE) && !(rsp_valid && rsp_stall);
	assign left_size = best_q - amt_q;

	assign active_sat = (num_blocks_q > 6'(MAX_BLOCKS)) ? CNT_BITS'(MAX_BLOCKS)
	                                                    : CNT_BITS'(num_blocks_q);

	// A load writes straight into the table; an allocate writes back only when granted.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pick_q;
		ram_wdata = left_size;
		if (accept && (req.req_type == REQ_LOAD)
		    && ({1'b0, req.block_index} < 6'(MAX_BLOCKS))) begin
			ram_we    = 1'b1;
			ram_waddr = IDX_BITS'(req.block_index);
			ram_wdata = SIZE_BITS'(req.amount);
		end else if (finish && found_q) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == ST_SCAN);

	// Entries never written since reset read as zero.
	assign entry_size = filled_q[rd_idx_s1] ? ram_rdata : '0;

	always_comb begin
		take = 1'b0;
		if (rd_vld_s1 && (entry_size >= amt_q)) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (mode_q)
					FIT_BEST:  take = (entry_size < best_q);
					FIT_WORST: take = (entry_size > best_q);
					default:   take = 1'b0;
				endcase
			end
		end
	end

	fpba_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fit_mode_q   <= FIT_FIRST;
			num_blocks_q <= '0;
			filled_q     <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			rsp_valid    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIT_MODE: begin
						// The unused mode code behaves as first fit.
						if (cfg_data[1:0] == 2'd3) begin
							fit_mode_q <= FIT_FIRST;
						end else begin
							fit_mode_q <= fit_mode_t'(cfg_data[1:0]);
						end
					end
					CFG_NUM_BLOCKS: num_blocks_q <= cfg_data;
					default: ;
				endcase
			end

			if (ram_we) begin
				filled_q[ram_waddr] <= 1'b1;
			end

			if (rsp_valid && !rsp_stall && !finish) begin
				rsp_valid <= 1'b0;
			end

			rd_vld_s1 <= ram_re;
			rd_idx_s1 <= cnt_q[IDX_BITS-1:0];

			if (take) begin
				found_q <= 1'b1;
				pick_q  <= rd_idx_s1;
				best_q  <= entry_size;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && (req.req_type == REQ_ALLOCATE)) begin
						mode_q   <= fit_mode_q;
						active_q <= active_sat;
						amt_q    <= SIZE_BITS'(req.amount);
						cnt_q    <= '0;
						found_q  <= 1'b0;
						state_q  <= (active_sat == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == active_q - 1'b1) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						rsp_valid <= 1'b1;
						rsp.granted      <= found_q;
						rsp.block_number <= found_q ? 5'(pick_q) : 5'd0;
						rsp.remaining    <= found_q ? 16'(left_size) : 16'd0;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("result posted outside the finish step");

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> (rsp.block_number == 5'd0) && (rsp.remaining == 16'd0))
		else $error("refused result carries a nonzero block or size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (cnt_q < active_q))
		else $error("scan address beyond the active blocks");

	a_no_wb_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && rsp_valid && rsp_stall |=> (state_q == ST_DONE))
		else $error("finish step left while the result register was full");
`endif

endmodule

// ===== hw/rtl/fpba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench for the fit-policy block allocator: directed table, random words, scoreboard.
`timescale 1ns / 1ps

module tb;
	import fpba_pkg::*;

	localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;
	localparam int QUIET_LIMIT   = 3000;
	localparam int CHUNKS        = 10;
	localparam int CHUNK_WORDS   = 100;
	localparam int SCRIPT_ROWS   = 32;
	localparam rsp_t REFUSED     = '0;

	typedef struct packed {
		logic       is_cfg;
		cfg_reg_t   sel;
		logic [5:0] cfg_val;
		req_t       word;
		logic       typed;
		rsp_t       want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	logic [SIZE_BITS-1:0] free_sizes [MAX_BLOCKS];
	logic [1:0] mode_shadow = '0;
	logic [5:0] active_shadow = '0;
	rsp_t pending_grants [$];
	rsp_t oldest_grant;
	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// Rows with typed = 0 take their expectation from the predictor.
	script_row_t script [SCRIPT_ROWS] = '{
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd0}, 1'b1, REFUSED},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd31, 16'hFFFF}, 1'b1, REFUSED},
		'{1'b1, CFG_NUM_BLOCKS, 6'd4, '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd0}, 1'b1, {1'b1, 5'd0, 16'd0}},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd0, 16'd100}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd1, 16'd50}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd2, 16'd200}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd3, 16'd50}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd60}, 1'b1, {1'b1, 5'd0, 16'd40}},
		'{1'b1, CFG_FIT_MODE, 6'(FIT_BEST), '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd45}, 1'b1, {1'b1, 5'd1, 16'd5}},
		'{1'b1, CFG_FIT_MODE, 6'(FIT_WORST), '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd10}, 1'b1, {1'b1, 5'd2, 16'd190}},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'hFFFF}, 1'b1, REFUSED},
		// Mode code 3 has no name and must act as first fit.
		'{1'b1, CFG_FIT_MODE, 6'd3, '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd30}, 1'b1, {1'b1, 5'd0, 16'd10}},
		'{1'b1, CFG_NUM_BLOCKS, 6'd63, '0, 1'b0, '0},
		'{1'b1, CFG_FIT_MODE, 6'(FIT_WORST), '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd31, 16'hFFFF}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'hFFFF}, 1'b1, {1'b1, 5'd31, 16'd0}},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd31, 16'h5555}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd30, 16'hAAAA}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'hAAAA}, 1'b1, {1'b1, 5'd30, 16'd0}},
		'{1'b1, CFG_NUM_BLOCKS, 6'd32, '0, 1'b0, '0},
		'{1'b1, CFG_FIT_MODE, 6'(FIT_BEST), '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd1}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd0}, 1'b0, '0},
		'{1'b1, CFG_NUM_BLOCKS, 6'd1, '0, 1'b0, '0},
		'{1'b1, CFG_FIT_MODE, 6'(FIT_FIRST), '0, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd0, 16'd11}, 1'b1, REFUSED},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_LOAD, 5'd0, 16'hFFFF}, 1'b0, '0},
		'{1'b0, CFG_FIT_MODE, 6'd0, {REQ_ALLOCATE, 5'd17, 16'h8000}, 1'b1,
			{1'b1, 5'd0, 16'h7FFF}}
	};

	fit_policy_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			free_sizes[i] = '0;
		end
	end

	// Applies a word to the free-size table and returns 1 when it yields a result.
	function automatic bit predict_grant(input req_t w, output rsp_t r);
		int unsigned span;
		int pick;
		bit found;
		fit_mode_t m;
		r = REFUSED;
		if (w.req_type == REQ_LOAD) begin
			free_sizes[w.block_index] = w.amount;
			return 1'b0;
		end
		span = (active_shadow > MAX_BLOCKS) ? MAX_BLOCKS : active_shadow;
		case (mode_shadow)
			FIT_BEST: m = FIT_BEST;
			FIT_WORST: m = FIT_WORST;
			default: m = FIT_FIRST;
		endcase
		found = 1'b0;
		pick = 0;
		for (int j = 0; j < span; j++) begin
			if (free_sizes[j] < w.amount) continue;
			if (!found) begin
				found = 1'b1;
				pick = j;
				if (m == FIT_FIRST) break;
			end else if (m == FIT_BEST) begin
				if (free_sizes[j] < free_sizes[pick]) pick = j;
			end else if (free_sizes[j] > free_sizes[pick]) begin
				pick = j;
			end
		end
		if (found) begin
			free_sizes[pick] = free_sizes[pick] - w.amount;
			r = {1'b1, 5'(pick), free_sizes[pick]};
		end
		return 1'b1;
	endfunction

	function automatic req_t random_word();
		req_t w;
		int unsigned span;
		span = (active_shadow == 0 || active_shadow > MAX_BLOCKS) ? MAX_BLOCKS : active_shadow;
		w.block_index = 5'($urandom_range(0, MAX_BLOCKS - 1));
		if ($urandom_range(0, 99) < 40) begin
			w.req_type = REQ_LOAD;
			// Loads mostly land on blocks that take part in the search.
			if ($urandom_range(0, 3) != 0) w.block_index = 5'($urandom_range(0, span - 1));
			if ($urandom_range(0, 7) == 0) begin
				w.amount = 16'($urandom);
			end else begin
				w.amount = 16'($urandom_range(0, 1000));
			end
		end else begin
			w.req_type = REQ_ALLOCATE;
			case ($urandom_range(0, 9))
				0: w.amount = '0;
				1: w.amount = 16'($urandom);
				default: w.amount = 16'($urandom_range(1, 300));
			endcase
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic set_pace(input int phase);
		case (phase)
			1: begin send_idle_pct = 69; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 69; end
			3: begin send_idle_pct = 24; stall_pct = 24; end
			default: begin send_idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	// Called and returns at a falling edge; valid is left high for the next word.
	task automatic send_word(input req_t w, input bit typed, input rsp_t want);
		rsp_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (predict_grant(w, predicted)) pending_grants.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Waits for every expected result, then for a possible load still in flight.
	task automatic drain_grants();
		req_valid <= 1'b0;
		while (pending_grants.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input cfg_reg_t sel, input logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (sel)
			CFG_FIT_MODE: mode_shadow = val[1:0];
			CFG_NUM_BLOCKS: active_shadow = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_grants.size() == 0) begin
				report_mismatch($sformatf("result word %h with none expected", rsp));
			end else begin
				oldest_grant = pending_grants.pop_front();
				if (rsp.granted !== oldest_grant.granted)
					report_mismatch($sformatf("granted %b, expected %b",
						rsp.granted, oldest_grant.granted));
				if (rsp.block_number !== oldest_grant.block_number)
					report_mismatch($sformatf("block_number %0d, expected %0d",
						rsp.block_number, oldest_grant.block_number));
				if (rsp.remaining !== oldest_grant.remaining)
					report_mismatch($sformatf("remaining %h, expected %h",
						rsp.remaining, oldest_grant.remaining));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [5:0] blocks;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_pace(0);
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			if (script[i].is_cfg) begin
				drain_grants();
				write_register(script[i].sel, script[i].cfg_val);
			end else begin
				send_word(script[i].word, script[i].typed, script[i].want);
			end
		end
		for (int c = 0; c < CHUNKS; c++) begin
			// Mostly small tables keep each search short; a few chunks use the extremes.
			case (c)
				2: blocks = 6'd32;
				5: blocks = 6'd63;
				7: blocks = 6'd0;
				8: blocks = 6'd33;
				default: blocks = 6'($urandom_range(1, 8));
			endcase
			drain_grants();
			write_register(CFG_FIT_MODE, 6'($urandom_range(0, 3)));
			write_register(CFG_NUM_BLOCKS, blocks);
			set_pace(c % 4);
			repeat (CHUNK_WORDS) send_word(random_word(), 1'b0, REFUSED);
		end
		drain_grants();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
